>>> rtl/core/tsp_pkg.sv
// Package for the transport stream section packetizer.
// Constants, request selectors and the controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps

package tsp_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned PktWords = 47;
    localparam int unsigned PosW     = 6;
    localparam int unsigned CcW      = 4;
    localparam int unsigned VbW      = 3;

    localparam logic [PosW-1:0]  LastPos  = PosW'(PktWords - 1);
    localparam logic [WordW-1:0] FillWord = 32'hFFFF_FFFF;
    localparam logic [7:0]       PusiMask = 8'hBF;
    localparam logic [7:0]       HiNibble = 8'hF0;
    localparam logic [7:0]       LoNibble = 8'h0F;

    typedef enum logic [1:0] {
        SEL_HDR,
        SEL_IN,
        SEL_HOLD,
        SEL_PAD
    } t_sel;

    typedef struct packed {
        logic emit;
        t_sel sel;
        logic eos;
        logic sec_end;
        logic save_hdr;
        logic cap_hold;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic pos_zero;
        logic first;
        logic at_eop;
        logic hold_last;
    } t_status;

endpackage

>>> rtl/core/tsp_datapath.sv
// Datapath of the section packetizer: header, position and continuity state,
// held input word and the output register.
// Depends on tsp_pkg.
`timescale 1ns / 1ps

module tsp_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tsp_pkg::t_cmd             i_cmd,
    output tsp_pkg::t_status          o_status,
    input  logic [tsp_pkg::WordW-1:0] i_data,
    input  logic [tsp_pkg::VbW-1:0]   i_valid_bytes,
    input  logic                      i_last,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [tsp_pkg::WordW-1:0] o_out_word,
    output logic                      o_out_eop,
    output logic                      o_out_eos
);

    logic [tsp_pkg::WordW-1:0] r_hdr;
    logic [tsp_pkg::PosW-1:0]  r_pos;
    logic [tsp_pkg::CcW-1:0]   r_cc;
    logic                      r_first;
    logic [tsp_pkg::WordW-1:0] r_hold;
    logic                      r_hold_last;
    logic [tsp_pkg::WordW-1:0] r_out_word;
    logic                      r_out_eop;
    logic                      r_out_eos;
    logic                      r_out_valid;

    logic [tsp_pkg::CcW-1:0]   n_cc_inc;
    logic [tsp_pkg::WordW-1:0] n_hdr_word;
    logic [tsp_pkg::WordW-1:0] n_in_word;
    logic [tsp_pkg::WordW-1:0] n_word;
    logic [tsp_pkg::WordW-1:0] keep;
    logic [7:0]                hb1;
    logic [7:0]                hb3;
    logic                      eop;

    // keep mask: 0 keeps nothing, 4..7 keep all
    always_comb begin
        case (i_valid_bytes)
            3'd0:    keep = 32'h0000_0000;
            3'd1:    keep = 32'hFF00_0000;
            3'd2:    keep = 32'hFFFF_0000;
            3'd3:    keep = 32'hFFFF_FF00;
            default: keep = 32'hFFFF_FFFF;
        endcase
    end

    assign n_in_word = i_last ? ((i_data & keep) | ~keep) : i_data;

    assign n_cc_inc = r_cc + 4'd1;
    assign hb1 = r_hdr[23:16] & tsp_pkg::PusiMask;
    assign hb3 = (r_hdr[7:0] & tsp_pkg::HiNibble)
               | ({4'd0, r_hdr[3:0] + n_cc_inc} & tsp_pkg::LoNibble);
    assign n_hdr_word = {r_hdr[31:24], hb1, r_hdr[15:8], hb3};

    always_comb begin
        unique case (i_cmd.sel)
            tsp_pkg::SEL_HDR:  n_word = n_hdr_word;
            tsp_pkg::SEL_IN:   n_word = n_in_word;
            tsp_pkg::SEL_HOLD: n_word = r_hold;
            tsp_pkg::SEL_PAD:  n_word = tsp_pkg::FillWord;
            default:           n_word = tsp_pkg::FillWord;
        endcase
    end

    assign eop = (r_pos == tsp_pkg::LastPos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr       <= '0;
            r_pos       <= '0;
            r_cc        <= '0;
            r_first     <= 1'b1;
            r_hold_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.save_hdr) begin
                r_hdr <= i_data;
            end
            if (i_cmd.cap_hold) begin
                r_hold      <= n_in_word;
                r_hold_last <= i_last;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_out_word  <= n_word;
                r_out_eop   <= eop;
                r_out_eos   <= eop & i_cmd.eos;
                if (i_cmd.sel == tsp_pkg::SEL_HDR) begin
                    r_cc <= n_cc_inc;
                end
                if (i_cmd.sec_end) begin
                    r_pos   <= '0;
                    r_cc    <= '0;
                    r_first <= 1'b1;
                end else if (eop) begin
                    r_pos   <= '0;
                    r_first <= 1'b0;
                end else begin
                    r_pos <= r_pos + 6'd1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.pos_zero  = (r_pos == '0);
    assign o_status.first     = r_first;
    assign o_status.at_eop    = eop;
    assign o_status.hold_last = r_hold_last;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_out_eop   = r_out_eop;
    assign o_out_eos   = r_out_eos;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= tsp_pkg::LastPos)
        else $error("packet position out of range");

    a_eos_on_eop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_eos |-> r_out_eop)
        else $error("section end off a packet boundary");

    a_sec_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && i_cmd.sec_end |=> r_first && r_pos == '0 && r_cc == '0)
        else $error("section state not restored");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_out_valid || i_out_ready)
        else $error("output register overwritten");

endmodule

>>> rtl/core/tsp_ctrl.sv
// Controller of the section packetizer: sequences header, data and fill
// words into the datapath output register.
// Depends on tsp_pkg.
`timescale 1ns / 1ps

module tsp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    input  tsp_pkg::t_status i_status,
    output tsp_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DATA,
        ST_PAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE) && i_status.out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd.emit     = 1'b0;
        o_cmd.sel      = tsp_pkg::SEL_IN;
        o_cmd.eos      = 1'b0;
        o_cmd.sec_end  = 1'b0;
        o_cmd.save_hdr = 1'b0;
        o_cmd.cap_hold = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.pos_zero && !i_status.first) begin
                        // continuation header first, word waits in hold
                        o_cmd.sel      = tsp_pkg::SEL_HDR;
                        o_cmd.cap_hold = 1'b1;
                        n_state        = ST_DATA;
                    end else begin
                        o_cmd.save_hdr = i_status.pos_zero;
                        o_cmd.eos      = i_in_last;
                        if (i_in_last) begin
                            if (i_status.at_eop) begin
                                o_cmd.sec_end = 1'b1;
                            end else begin
                                n_state = ST_PAD;
                            end
                        end
                    end
                end
            end
            ST_DATA: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = tsp_pkg::SEL_HOLD;
                    o_cmd.eos  = i_status.hold_last;
                    if (i_status.hold_last && !i_status.at_eop) begin
                        n_state = ST_PAD;
                    end else begin
                        o_cmd.sec_end = i_status.hold_last;
                        n_state       = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = tsp_pkg::SEL_PAD;
                    o_cmd.eos  = 1'b1;
                    if (i_status.at_eop) begin
                        o_cmd.sec_end = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_pad_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PAD |-> !o_in_ready && (!o_cmd.emit || o_cmd.sel == tsp_pkg::SEL_PAD))
        else $error("input taken during fill");

    a_hdr_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit && o_cmd.sel == tsp_pkg::SEL_HDR |=> r_state == ST_DATA)
        else $error("header not followed by held word");

    a_pad_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_PAD && n_state == ST_PAD |-> o_cmd.emit && o_cmd.eos)
        else $error("fill started without section end");

endmodule

>>> rtl/core/ts_section_packetizer.sv
// Top level of the transport stream section packetizer.
// Depends on tsp_pkg, tsp_ctrl and tsp_datapath.
// Splits a table section into 47-word (188-byte) packets. Each accepted
// word leaves in the following cycle through an output register (but one
// that opens a continuation packet), so while the receiver keeps up a
// steady stream moves at one word per cycle; the single output port sets
// that figure. A continuation word waits in hold behind its new header;
// after a section's last word, input waits for up to 46 0xFF-byte fills.
`timescale 1ns / 1ps

module ts_section_packetizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] data_word
    input  logic [2:0]  i_s_tuser,   // [2:0] valid_bytes
    input  logic        i_s_tlast,   // is_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] packet_word
    output logic [0:0]  o_m_tuser,   // [0] end_of_section
    output logic        o_m_tlast    // end_of_packet
);

    tsp_pkg::t_cmd    cmd;
    tsp_pkg::t_status status;

    tsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_last  (i_s_tlast),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tsp_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_data        (i_s_tdata),
        .i_valid_bytes (i_s_tuser),
        .i_last        (i_s_tlast),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_out_word    (o_m_tdata),
        .o_out_eop     (o_m_tlast),
        .o_out_eos     (o_m_tuser[0])
    );

endmodule

>>> dv/tsp_checker.sv
// Checker for the transport stream section packetizer: watches both stream ports,
// predicts every packet word from the accepted table words and compares them in order.
// Depends on tsp_pkg.
`timescale 1ns / 1ps

module tsp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] data_word
    input  logic [2:0]  i_s_tuser,   // [2:0] valid_bytes
    input  logic        i_s_tlast,   // is_last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [31:0] packet_word
    input  logic [0:0]  i_m_tuser,   // [0] end_of_section
    input  logic        i_m_tlast,   // end_of_packet
    output int          o_fail_count,
    output int          o_words_pending,
    output int          o_words_checked,
    output int          o_cont_headers
);

    typedef struct packed {
        logic [31:0] word;
        logic        eop;
        logic        eos;
    } t_pkt_word;

    t_pkt_word   words_due[$];
    t_pkt_word   got_word;
    logic [31:0] hdr_saved;
    logic [5:0]  pkt_pos;
    logic [3:0]  cont_count;
    logic        first_pkt;

    initial begin
        o_fail_count    = 0;
        o_words_pending = 0;
        o_words_checked = 0;
        o_cont_headers  = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t ns] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic queue_word(input logic [31:0] w, input logic sec_end);
        t_pkt_word pw;
        pw.word = w;
        pw.eop  = (pkt_pos == tsp_pkg::LastPos);
        pw.eos  = pw.eop && sec_end;
        words_due.push_back(pw);
        if (pw.eop) begin
            pkt_pos   = '0;
            first_pkt = 1'b0;
        end else begin
            pkt_pos = pkt_pos + 1'b1;
        end
    endtask

    function automatic logic [31:0] cont_header();
        logic [7:0] b1;
        logic [7:0] b3;
        b1 = hdr_saved[23:16] & tsp_pkg::PusiMask;
        b3 = (hdr_saved[7:0] & tsp_pkg::HiNibble)
           | ((hdr_saved[7:0] + {4'h0, cont_count}) & tsp_pkg::LoNibble);
        return {hdr_saved[31:24], b1, hdr_saved[15:8], b3};
    endfunction

    task automatic predict_packets(input logic [31:0] d, input logic [2:0] vb, input logic lst);
        logic [31:0] keep;
        if (pkt_pos >= 6'(tsp_pkg::PktWords))
            pkt_pos = '0;
        if (pkt_pos == '0) begin
            if (first_pkt) begin
                hdr_saved = d;
            end else begin
                cont_count = cont_count + 1'b1;
                queue_word(cont_header(), 1'b0);
                o_cont_headers++;
            end
        end
        if (lst) begin
            keep = (vb >= 3'd4) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> (8 * vb));
            queue_word((d & keep) | ~keep, 1'b1);
            while (pkt_pos != '0)
                queue_word(tsp_pkg::FillWord, 1'b1);
            cont_count = '0;
            first_pkt  = 1'b1;
        end else begin
            queue_word(d, 1'b0);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hdr_saved  = '0;
            pkt_pos    = '0;
            cont_count = '0;
            first_pkt  = 1'b1;
            words_due.delete();
        end else begin
            // outputs are registered after their request, so retire before predicting
            if (i_m_tvalid && i_m_tready) begin
                o_words_checked++;
                if (words_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", i_m_tdata));
                end else begin
                    got_word = words_due.pop_front();
                    if (i_m_tdata !== got_word.word)
                        report_mismatch($sformatf("packet_word expected %h got %h",
                                                  got_word.word, i_m_tdata));
                    if (i_m_tlast !== got_word.eop)
                        report_mismatch($sformatf("end_of_packet expected %b got %b (word %h)",
                                                  got_word.eop, i_m_tlast, got_word.word));
                    if (i_m_tuser[0] !== got_word.eos)
                        report_mismatch($sformatf("end_of_section expected %b got %b (word %h)",
                                                  got_word.eos, i_m_tuser[0], got_word.word));
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_packets(i_s_tdata, i_s_tuser, i_s_tlast);
        end
        o_words_pending = words_due.size();
    end

endmodule

>>> dv/tb.sv
// Testbench top for ts_section_packetizer: drives table sections with bursty
// requests and a stalling receiver, and gives the verdict from tsp_checker.
// Depends on tsp_pkg, tsp_checker and the packetizer RTL.
`timescale 1ns / 1ps

module tb;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int words_pending;
    int words_checked;
    int cont_headers;
    int burst_left;
    int words_sent;
    int sections_sent;
    int rx_cycle;
    int rx_mode;

    ts_section_packetizer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    tsp_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_s_tlast       (s_tlast),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .i_m_tlast       (m_tlast),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending),
        .o_words_checked (words_checked),
        .o_cont_headers  (cont_headers)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d packet words outstanding", words_pending);
        $display("Regression FAIL");
        $finish;
    end

    // receiver: stall style is redrawn at random from four modes
    initial begin
        m_tready = 1'b0;
        rx_cycle = 0;
        rx_mode  = 0;
    end

    always @(negedge clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= $urandom_range(0, 1);
            end
            2: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                m_tready <= (rx_cycle % 8 == 0);
            end
        endcase
    end

    task automatic send_word(input logic [31:0] d, input logic [2:0] vb, input logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= vb;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        burst_left--;
        words_sent++;
    endtask

    task automatic send_section(input int len);
        for (int i = 0; i < len; i++)
            send_word($urandom, 3'($urandom_range(0, 7)), i == len - 1);
        sections_sent++;
    endtask

    initial begin
        int len;
        int rand_words;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        s_tlast       = 1'b0;
        burst_left    = 0;
        words_sent    = 0;
        sections_sent = 0;
        rand_words    = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 1- and 2-word sections: data extremes, every valid_bytes code 0..7
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        for (int vb = 0; vb < 8; vb++)
            send_word($urandom, 3'(vb), 1'b1);
        send_word(32'h4740_001F, 3'd7, 1'b0);
        send_word(32'h0000_0000, 3'd1, 1'b1);
        sections_sent += 11;

        // random sections, weighted toward exact packet fills and continuations
        while (rand_words < 158) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = $urandom_range(1, 12);
                4, 5:       len = $urandom_range(13, 100);
                6:          len = 47;
                7:          len = 93;
                8:          len = 48;
                default:    len = $urandom_range(140, 190);
            endcase
            if (len > 158 - rand_words)
                len = 158 - rand_words;
            send_section(len);
            rand_words += len;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (words_pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Sent %0d table words in %0d sections under random bursts and stalls.",
                 words_sent, sections_sent);
        $display("Checked %0d packet words, %0d of them continuation headers.",
                 words_checked, cont_headers);
        if (fail_count == 0 && words_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/tsp_pkg.sv
rtl/core/tsp_datapath.sv
rtl/core/tsp_ctrl.sv
rtl/core/ts_section_packetizer.sv
dv/tsp_checker.sv
dv/tb.sv
